// File: src/crc16_frame_deframer_defines.svh
// Assertion macros used by the deframer RTL.
`ifndef CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

`define CFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`else

`define CFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/cfd_pkg.sv
package cfd_pkg;

	localparam logic [15:0] MIN_FRAME_LEN = 16'd10;
	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

	localparam logic [1:0] CFG_HEAD = 2'd0;
	localparam logic [1:0] CFG_TAIL = 2'd1;
	localparam logic [1:0] CFG_POLY = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CRC  = 2'd1,
		ST_TAIL = 2'd2,
		ST_LEN  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_HUNT = 6'b000001,
		PH_LEN  = 6'b000010,
		PH_VER  = 6'b000100,
		PH_PAY  = 6'b001000,
		PH_CRC  = 6'b010000,
		PH_TAIL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [15:0] head_word;
		logic [15:0] tail_word;
		logic [15:0] crc_poly;
	} cfg_t;

	typedef struct packed {
		logic        hit;
		logic [7:0]  out_byte;
		logic        frame_end;
		status_t     status;
	} res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
		input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: src/cfd_core.sv
module cfd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	input  cfd_pkg::cfg_t     cfg,
	output cfd_pkg::res_t     res
);

	cfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic        prev_valid_q, prev_valid_d;
	logic [15:0] idx_q, idx_d;
	logic [15:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [7:0]  tail_low_q, tail_low_d;

	logic [15:0] crc_step;
	logic [15:0] idx_inc;
	logic [15:0] len_full;
	logic [15:0] len_m4;
	logic [15:0] len_m2;
	logic [15:0] tail_rx;

	assign crc_step = cfd_pkg::crc16_byte(crc_q, data, cfg.crc_poly);
	assign idx_inc  = idx_q + 16'd1;
	assign len_full = len_q | {data, 8'h00};
	assign len_m4   = len_q - 16'd4;
	assign len_m2   = len_q - 16'd2;
	assign tail_rx  = {data, tail_low_q};

	always_comb begin
		phase_d      = phase_q;
		prev_d       = prev_q;
		prev_valid_d = prev_valid_q;
		idx_d        = idx_q;
		len_d        = len_q;
		crc_d        = crc_q;
		rcrc_d       = rcrc_q;
		tail_low_d   = tail_low_q;
		res          = '0;
		case (phase_q)
			cfd_pkg::PH_LEN: begin
				crc_d = crc_step;
				if (idx_q == 16'd2) begin
					len_d = {8'h00, data};
					idx_d = 16'd3;
				end else begin
					len_d = len_full;
					if (len_full < cfd_pkg::MIN_FRAME_LEN) begin
						res.hit       = 1'b1;
						res.frame_end = 1'b1;
						res.status    = cfd_pkg::ST_LEN;
						phase_d       = cfd_pkg::PH_HUNT;
						prev_valid_d  = 1'b0;
					end else begin
						idx_d   = 16'd4;
						phase_d = cfd_pkg::PH_VER;
					end
				end
			end
			cfd_pkg::PH_VER: begin
				crc_d = crc_step;
				idx_d = idx_inc;
				if (idx_inc == 16'd6) begin
					phase_d = (len_q == cfd_pkg::MIN_FRAME_LEN) ? cfd_pkg::PH_CRC
						: cfd_pkg::PH_PAY;
				end
			end
			cfd_pkg::PH_PAY: begin
				crc_d = crc_step;
				idx_d = idx_inc;
				if (idx_inc == len_m4) begin
					phase_d = cfd_pkg::PH_CRC;
				end
				res.hit      = 1'b1;
				res.out_byte = data;
			end
			cfd_pkg::PH_CRC: begin
				if (idx_q == len_m4) begin
					rcrc_d = {8'h00, data};
				end else begin
					rcrc_d  = rcrc_q | {data, 8'h00};
					phase_d = cfd_pkg::PH_TAIL;
				end
				idx_d = idx_inc;
			end
			cfd_pkg::PH_TAIL: begin
				if (idx_q == len_m2) begin
					tail_low_d = data;
					idx_d      = idx_inc;
				end else begin
					res.hit       = 1'b1;
					res.frame_end = 1'b1;
					if (tail_rx != cfg.tail_word) begin
						res.status = cfd_pkg::ST_TAIL;
					end else if (crc_q != rcrc_q) begin
						res.status = cfd_pkg::ST_CRC;
					end else begin
						res.status = cfd_pkg::ST_OK;
					end
					phase_d      = cfd_pkg::PH_HUNT;
					prev_valid_d = 1'b0;
				end
			end
			default: begin
				if (prev_valid_q && ({data, prev_q} == cfg.head_word)) begin
					phase_d      = cfd_pkg::PH_LEN;
					idx_d        = 16'd2;
					crc_d        = '0;
					prev_valid_d = 1'b0;
				end else begin
					phase_d      = cfd_pkg::PH_HUNT;
					prev_d       = data;
					prev_valid_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cfd_pkg::PH_HUNT;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			idx_q        <= '0;
			len_q        <= '0;
			crc_q        <= '0;
			rcrc_q       <= '0;
			tail_low_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			prev_q       <= prev_d;
			prev_valid_q <= prev_valid_d;
			idx_q        <= idx_d;
			len_q        <= len_d;
			crc_q        <= crc_d;
			rcrc_q       <= rcrc_d;
			tail_low_q   <= tail_low_d;
		end
	end

endmodule

// File: src/crc16_frame_deframer.sv
// channel | direction | handshake          | word
// in      | in        | in_valid/in_stall   | in_byte
// out     | out       | out_valid/out_stall | out_byte, frame_end, status
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled; a result word is registered once its
// byte is accepted and the parse stage advances. The byte-wide CRC update and frame parse
// are combinational between input and output registers. Asynchronous active-low reset returns
// the parser to head hunt. A stalled output holds the parse stage; in_stall rises while that
// stage is full and held. Config writes always complete in the cycle they are offered.
`include "crc16_frame_deframer_defines.svh"

module crc16_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              in_take;
	cfd_pkg::cfg_t     cfg_q;
	cfd_pkg::res_t     res;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              frame_end_q;
	cfd_pkg::status_t  status_q;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_word <= '0;
			cfg_q.tail_word <= '0;
			cfg_q.crc_poly  <= cfd_pkg::CRC_POLY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfd_pkg::CFG_HEAD: cfg_q.head_word <= cfg_data;
				cfd_pkg::CFG_TAIL: cfg_q.tail_word <= cfg_data;
				cfd_pkg::CFG_POLY: cfg_q.crc_poly  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	cfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.hit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= res.out_byte;
			frame_end_q <= res.frame_end;
			status_q    <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign status    = status_q;

	`CFD_ASSERT_IMPLY(a_end_zero_byte, clk, arst_n, out_valid_q && frame_end_q, out_byte_q == 8'h00)
	`CFD_ASSERT_IMPLY(a_pay_status_ok, clk, arst_n, out_valid_q && !frame_end_q, status_q == cfd_pkg::ST_OK)
	`CFD_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall)
	`CFD_ASSERT_NEXT(a_advance_drains, clk, arst_n, advance && !in_take, !valid_s1)

endmodule
